// File: sv/tets_pkg.sv
`default_nettype none
package tets_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int MAX_RESULTS = 32;
	localparam int KW = $clog2(MAX_RESULTS + 1);

	localparam int TW = 33;
	localparam int TAGW = 32;

	localparam logic [TW-1:0] TIME_MIN = 33'd1577836800;
	localparam logic [TW-1:0] TIME_MAX = 33'd4102444800;
	localparam logic [TW-1:0] SYNC_MIN = 33'd1000000000;
	localparam logic [TW:0] DAY_SECONDS = 34'd86400;
	localparam logic [5:0] MAX_EVENTS_RST = 6'd5;

	typedef enum logic [1:0] {
		MODE_RELOAD = 2'd0,
		MODE_ADD = 2'd1,
		MODE_TICK = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		STS_OK = 4'd0,
		STS_MISSING = 4'd1,
		STS_ORDER = 4'd2,
		STS_RANGE = 4'd3,
		STS_DUP = 4'd4,
		STS_FULL = 4'd5,
		STS_FIRED = 4'd6,
		STS_NONE = 4'd7,
		STS_RELOAD = 4'd8
	} sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_TICK_SCAN
	} state_t;

	typedef struct packed {
		logic [TW-1:0] start_t;
		logic [TW-1:0] end_t;
		logic [TAGW-1:0] tag;
		logic fired;
	} entry_t;

	typedef struct packed {
		logic live_match;
		logic prior_match;
		logic keep;
		logic active;
	} cmp_t;

endpackage
`default_nettype wire

// File: sv/tets_ram.sv
`default_nettype none
module tets_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: sv/tets_cmp.sv
`default_nettype none
module tets_cmp import tets_pkg::*; (
	input wire entry_t live,
	input wire entry_t prior,
	input wire logic [TW-1:0] key_start,
	input wire logic [TAGW-1:0] key_tag,
	input wire logic [TW-1:0] now,
	output cmp_t res
);

	always_comb begin
		res.live_match = (live.start_t == key_start) && (live.tag == key_tag);
		res.prior_match = (prior.start_t == key_start) && (prior.tag == key_tag);
		// expiry sum carried one bit wider so it never wraps
		res.keep = ({1'b0, now} < ({1'b0, live.end_t} + DAY_SECONDS));
		res.active = (now >= live.start_t) && (now < live.end_t);
	end

endmodule
`default_nettype wire

// File: sv/timed_event_table_scheduler.sv
`default_nettype none
// reload, rejected add, unsynced tick: one result, in the cycle after the transaction, never busy
// accepted add: busy while both banks are scanned up to max(live count, prior count), result next
// tick: busy while the live entries are scanned, entries compacted through one ram port
// results are strobed for one cycle each and cannot be stalled; busy is high while scanning
// arst_n clears counts and bank select and sets max_events to 5; table contents are not cleared
module timed_event_table_scheduler import tets_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] mode,
	input wire logic [32:0] start_time,
	input wire logic [32:0] end_time,
	input wire logic [31:0] title_tag,
	input wire logic [32:0] current_time,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [5:0] cfg_data,
	output logic result_valid,
	output logic [3:0] status,
	output logic [4:0] slot,
	output logic [31:0] event_tag,
	output logic last
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int EW = $bits(entry_t);

	state_t state_q, state_d;
	logic [CW-1:0] idx_q, idx_d, wr_q, wr_d, n_q, n_d, pc_q, pc_d;
	logic [KW-1:0] k_q, k_d;
	logic bank_q, bank_d;
	logic vld_s1, vld_d;
	logic [AW-1:0] idx_s1;
	logic [5:0] max_events_q;
	logic dup_q, dup_d, pm_q, pm_d, pf_q, pf_d, pv_q, pv_d;
	logic [AW-1:0] ps_q, ps_d;
	logic [TAGW-1:0] pt_q, pt_d;
	logic [TW-1:0] key_start_q, key_end_q, now_q;
	logic [TAGW-1:0] key_tag_q;
	logic load_key;

	logic emit, e_last;
	sts_t e_sts;
	logic [4:0] e_slot;
	logic [TAGW-1:0] e_tag;
	logic res_vld_q, res_last_q;
	logic [3:0] res_sts_q;
	logic [4:0] res_slot_q;
	logic [TAGW-1:0] res_tag_q;

	logic we, we0, we1;
	logic [AW-1:0] waddr, raddr;
	entry_t wdata, rd0, rd1, live_rd, prior_rd;
	cmp_t cmp;

	logic [CW-1:0] limit, scan_end, idx_s1_ext;
	logic [31:0] n_ext, ps_ext;
	logic accept, fire, fired_new;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign n_ext = 32'(n_q);
	assign ps_ext = 32'(ps_q);
	assign idx_s1_ext = CW'(idx_s1);
	assign scan_end = (n_q > pc_q) ? n_q : pc_q;
	assign limit = ({26'd0, max_events_q} > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
		: CW'(max_events_q);

	// double-banked table: reload swaps roles instead of copying
	assign we0 = we && !bank_q;
	assign we1 = we && bank_q;
	assign live_rd = bank_q ? rd1 : rd0;
	assign prior_rd = bank_q ? rd0 : rd1;

	tets_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH), .AW(AW)) u_ram0 (
		.clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0)
	);

	tets_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH), .AW(AW)) u_ram1 (
		.clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
	);

	tets_cmp u_cmp (
		.live(live_rd), .prior(prior_rd), .key_start(key_start_q), .key_tag(key_tag_q),
		.now(now_q), .res(cmp)
	);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		vld_d = 1'b0;
		wr_d = wr_q;
		k_d = k_q;
		n_d = n_q;
		pc_d = pc_q;
		bank_d = bank_q;
		dup_d = dup_q;
		pm_d = pm_q;
		pf_d = pf_q;
		pv_d = pv_q;
		ps_d = ps_q;
		pt_d = pt_q;
		load_key = 1'b0;
		emit = 1'b0;
		e_sts = STS_OK;
		e_slot = 5'd0;
		e_tag = '0;
		e_last = 1'b1;
		we = 1'b0;
		waddr = '0;
		wdata = live_rd;
		raddr = idx_q[AW-1:0];
		fire = 1'b0;
		fired_new = live_rd.fired;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (mode_t'(mode))
						MODE_RELOAD: begin
							bank_d = !bank_q;
							pc_d = n_q;
							n_d = '0;
							emit = 1'b1;
							e_sts = STS_RELOAD;
						end
						MODE_ADD: begin
							e_slot = n_ext[4:0];
							e_tag = title_tag;
							priority if (n_q >= limit) begin
								emit = 1'b1;
								e_sts = STS_FULL;
							end else if (start_time == '0 || end_time == '0) begin
								emit = 1'b1;
								e_sts = STS_MISSING;
							end else if (end_time <= start_time) begin
								emit = 1'b1;
								e_sts = STS_ORDER;
							end else if (start_time < TIME_MIN || start_time > TIME_MAX) begin
								emit = 1'b1;
								e_sts = STS_RANGE;
							end else begin
								load_key = 1'b1;
								idx_d = '0;
								dup_d = 1'b0;
								pm_d = 1'b0;
								pf_d = 1'b0;
								state_d = ST_ADD_SCAN;
							end
						end
						MODE_TICK: begin
							if (current_time < SYNC_MIN) begin
								emit = 1'b1;
								e_sts = STS_NONE;
							end else begin
								load_key = 1'b1;
								idx_d = '0;
								wr_d = '0;
								k_d = '0;
								pv_d = 1'b0;
								state_d = ST_TICK_SCAN;
							end
						end
						MODE_NONE: ;
					endcase
				end
			end
			ST_ADD_SCAN: begin
				if (idx_q < scan_end) begin
					vld_d = 1'b1;
					idx_d = idx_q + 1'b1;
				end
				if (vld_s1) begin
					if (idx_s1_ext < n_q && cmp.live_match) begin
						dup_d = 1'b1;
					end
					// first prior match wins
					if (idx_s1_ext < pc_q && cmp.prior_match && !pm_q) begin
						pm_d = 1'b1;
						pf_d = prior_rd.fired;
					end
				end else if (idx_q >= scan_end) begin
					emit = 1'b1;
					e_slot = n_ext[4:0];
					e_tag = key_tag_q;
					state_d = ST_IDLE;
					if (dup_q) begin
						e_sts = STS_DUP;
					end else begin
						e_sts = STS_OK;
						we = 1'b1;
						waddr = n_q[AW-1:0];
						wdata = '{start_t: key_start_q, end_t: key_end_q, tag: key_tag_q,
							fired: pf_q};
						n_d = n_q + 1'b1;
					end
				end
			end
			ST_TICK_SCAN: begin
				if (idx_q < n_q) begin
					vld_d = 1'b1;
					idx_d = idx_q + 1'b1;
				end
				if (vld_s1) begin
					if (cmp.keep) begin
						if (cmp.active && !live_rd.fired) begin
							if (k_q < KW'(MAX_RESULTS)) begin
								fire = 1'b1;
								fired_new = 1'b1;
							end
						end else if (!cmp.active && live_rd.fired) begin
							fired_new = 1'b0;
						end
						// compacting write trails the read address
						we = 1'b1;
						waddr = wr_q[AW-1:0];
						wdata = live_rd;
						wdata.fired = fired_new;
						wr_d = wr_q + 1'b1;
						if (fire) begin
							k_d = k_q + 1'b1;
							pv_d = 1'b1;
							ps_d = wr_q[AW-1:0];
							pt_d = live_rd.tag;
							// previous fire is now known not to be the last
							if (pv_q) begin
								emit = 1'b1;
								e_sts = STS_FIRED;
								e_slot = ps_ext[4:0];
								e_tag = pt_q;
								e_last = 1'b0;
							end
						end
					end
				end else if (idx_q >= n_q) begin
					n_d = wr_q;
					state_d = ST_IDLE;
					emit = 1'b1;
					if (pv_q) begin
						e_sts = STS_FIRED;
						e_slot = ps_ext[4:0];
						e_tag = pt_q;
					end else begin
						e_sts = STS_NONE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			wr_q <= '0;
			k_q <= '0;
			n_q <= '0;
			pc_q <= '0;
			bank_q <= 1'b0;
			vld_s1 <= 1'b0;
			pv_q <= 1'b0;
			res_vld_q <= 1'b0;
			max_events_q <= MAX_EVENTS_RST;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			wr_q <= wr_d;
			k_q <= k_d;
			n_q <= n_d;
			pc_q <= pc_d;
			bank_q <= bank_d;
			vld_s1 <= vld_d;
			pv_q <= pv_d;
			res_vld_q <= emit;
			if (cfg_valid && cfg_ready) begin
				max_events_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[AW-1:0];
		dup_q <= dup_d;
		pm_q <= pm_d;
		pf_q <= pf_d;
		ps_q <= ps_d;
		pt_q <= pt_d;
		if (load_key) begin
			key_start_q <= start_time;
			key_end_q <= end_time;
			key_tag_q <= title_tag;
			now_q <= current_time;
		end
		res_sts_q <= e_sts;
		res_slot_q <= e_slot;
		res_tag_q <= e_tag;
		res_last_q <= e_last;
	end

	assign result_valid = res_vld_q;
	assign status = res_sts_q;
	assign slot = res_slot_q;
	assign event_tag = res_tag_q;
	assign last = res_last_q;

endmodule
`default_nettype wire

// File: sv/tets_chk.sv
`default_nettype none
module tets_chk import tets_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [1:0] mode,
	input wire logic result_valid,
	input wire logic [3:0] status,
	input wire logic last
);

	a_reload_reply: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_RELOAD |=> result_valid && last && status == STS_RELOAD)
		else $error("reload did not answer next cycle");

	a_unused_mode_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_NONE |=> !result_valid)
		else $error("unused mode produced a result");

	a_more_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("non-final result while idle");

	a_none_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == STS_NONE |-> last)
		else $error("none-fired result not final");

endmodule

bind timed_event_table_scheduler tets_chk u_tets_chk (.*);
`default_nettype wire
